>>> hdl/stsi_pkg.sv
package stsi_pkg;

    // Fixed field widths of the request and response words.
    localparam int KEY_IN_W = 32;
    localparam int INDEX_W  = 8;

    // Request word: operation and key.
    typedef struct packed {
        logic                kind;
        logic [KEY_IN_W-1:0] key;
    } t_in_word;

    // Response word.
    typedef struct packed {
        logic               found;
        logic [INDEX_W-1:0] index;
        logic               full_error;
    } t_out_word;

    // Operation codes carried in the request word.
    localparam logic KIND_FIND = 1'b0;
    localparam logic KIND_ADD  = 1'b1;

    // Datapath operations selected by the control word.
    typedef enum logic [3:0] {
        OP_NOP,
        OP_TAKE,
        OP_INIT,
        OP_PROBE,
        OP_COMPARE,
        OP_POS_MID,
        OP_POS_END,
        OP_POS_COUNT,
        OP_SH_INIT,
        OP_SH_MOVE,
        OP_STORE,
        OP_RES_FOUND,
        OP_RES_MISS,
        OP_RES_ERR,
        OP_OUT_LOAD
    } t_op;

    // Jump conditions; when the condition holds the sequencer goes to the target.
    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_INPUT,
        C_FULL_ADD,
        C_NO_SEARCH,
        C_SEARCH_DONE,
        C_NE,
        C_IS_ADD,
        C_SH_MORE,
        C_OUT_FREE
    } t_cond;

    typedef logic [4:0] t_step;

    // Program addresses.
    localparam t_step STEP_IDLE     = 5'd0;
    localparam t_step STEP_DISP     = 5'd1;
    localparam t_step STEP_MODE     = 5'd2;
    localparam t_step STEP_INIT     = 5'd3;
    localparam t_step STEP_LOOP     = 5'd4;
    localparam t_step STEP_CMP      = 5'd5;
    localparam t_step STEP_MATCH    = 5'd6;
    localparam t_step STEP_HIT      = 5'd7;
    localparam t_step STEP_ENDS     = 5'd8;
    localparam t_step STEP_MISS     = 5'd9;
    localparam t_step STEP_NOSRCH   = 5'd10;
    localparam t_step STEP_NOMISS   = 5'd11;
    localparam t_step STEP_APPEND   = 5'd12;
    localparam t_step STEP_SH_INIT  = 5'd13;
    localparam t_step STEP_SH_LOOP  = 5'd14;
    localparam t_step STEP_STORE    = 5'd15;
    localparam t_step STEP_ERR      = 5'd16;
    localparam t_step STEP_OUT      = 5'd17;
    localparam t_step STEP_OUT_WAIT = 5'd18;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_step target;
    } t_uword;

    function automatic t_uword uw(input t_op op, input t_cond cond, input t_step target);
        t_uword w;
        w.op     = op;
        w.cond   = cond;
        w.target = target;
        return w;
    endfunction

    // Control program. Without a taken jump the sequencer steps to the next address.
    function automatic t_uword ucode_rom(input t_step s);
        t_uword w;
        unique case (s)
            STEP_IDLE:     w = uw(OP_TAKE,      C_NO_INPUT,    STEP_IDLE);
            STEP_DISP:     w = uw(OP_NOP,       C_FULL_ADD,    STEP_ERR);
            STEP_MODE:     w = uw(OP_NOP,       C_NO_SEARCH,   STEP_NOSRCH);
            STEP_INIT:     w = uw(OP_INIT,      C_NEVER,       STEP_IDLE);
            STEP_LOOP:     w = uw(OP_PROBE,     C_SEARCH_DONE, STEP_ENDS);
            STEP_CMP:      w = uw(OP_COMPARE,   C_NE,          STEP_LOOP);
            STEP_MATCH:    w = uw(OP_POS_MID,   C_IS_ADD,      STEP_SH_INIT);
            STEP_HIT:      w = uw(OP_RES_FOUND, C_ALWAYS,      STEP_OUT);
            STEP_ENDS:     w = uw(OP_POS_END,   C_IS_ADD,      STEP_SH_INIT);
            STEP_MISS:     w = uw(OP_RES_MISS,  C_ALWAYS,      STEP_OUT);
            STEP_NOSRCH:   w = uw(OP_NOP,       C_IS_ADD,      STEP_APPEND);
            STEP_NOMISS:   w = uw(OP_RES_MISS,  C_ALWAYS,      STEP_OUT);
            STEP_APPEND:   w = uw(OP_POS_COUNT, C_ALWAYS,      STEP_STORE);
            STEP_SH_INIT:  w = uw(OP_SH_INIT,   C_NEVER,       STEP_IDLE);
            STEP_SH_LOOP:  w = uw(OP_SH_MOVE,   C_SH_MORE,     STEP_SH_LOOP);
            STEP_STORE:    w = uw(OP_STORE,     C_ALWAYS,      STEP_OUT);
            STEP_ERR:      w = uw(OP_RES_ERR,   C_ALWAYS,      STEP_OUT);
            STEP_OUT:      w = uw(OP_OUT_LOAD,  C_OUT_FREE,    STEP_IDLE);
            STEP_OUT_WAIT: w = uw(OP_NOP,       C_ALWAYS,      STEP_OUT);
            default:       w = uw(OP_NOP,       C_ALWAYS,      STEP_IDLE);
        endcase
        return w;
    endfunction

endpackage

>>> hdl/sorted_table_search_insert_unit.sv
// Sorted key table with binary search and ordered insert. A find word searches the held keys
// and answers found and the matching slot; an add word stores its key at the place that keeps
// the table in ascending unsigned order (ahead of an equal key) and answers that slot, or
// answers full_error when DEPTH keys are already held. With sorted_mode at 0, find always
// misses and add appends. One word is worked at a time by a small microcoded sequencer over a
// single-port-write, single-port-read key memory. A find runs a probe loop of one memory read
// and one compare per probe; an add then moves every key above its slot up by one place,
// one key per memory write. The input side takes a new word only while the sequencer is
// idle; a finished answer sits in an output register, so the next word can be taken before
// the answer is collected.
module sorted_table_search_insert_unit #(
    parameter int DEPTH     = 256,
    parameter int KEY_WIDTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_wdata,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  stsi_pkg::t_in_word i_in,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output stsi_pkg::t_out_word o_out
);
    import stsi_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    // Sequencer and control state.
    t_step           r_step;
    t_step           n_step;
    t_uword          w_uw;
    logic            w_jump;
    logic            r_sorted;
    logic [CW-1:0]   r_count;
    logic [CW-1:0]   n_count;
    logic            r_out_valid;

    // Datapath registers.
    logic                 r_kind;
    logic [KEY_WIDTH-1:0] r_key;
    logic [CW-1:0]        r_lo;
    logic [CW-1:0]        n_lo;
    logic [CW-1:0]        r_hx;
    logic [CW-1:0]        n_hx;
    logic [AW-1:0]        r_mid;
    logic [AW-1:0]        n_mid;
    logic                 r_cmp_gt;
    logic                 n_cmp_gt;
    logic [CW-1:0]        r_pos;
    logic [CW-1:0]        n_pos;
    logic [AW-1:0]        r_sp;
    logic [AW-1:0]        n_sp;
    t_out_word            r_res;
    t_out_word            n_res;
    t_out_word            r_out;

    // Key memory.
    logic [KEY_WIDTH-1:0] mem [DEPTH];
    logic [KEY_WIDTH-1:0] r_rdata;
    logic [AW-1:0]        w_rd_addr;
    logic [AW-1:0]        w_wr_addr;
    logic [KEY_WIDTH-1:0] w_wr_data;
    logic                 w_we;

    // Derived values.
    logic [CW:0]   w_mid_sum;
    logic [AW-1:0] w_mid;
    logic          w_gt;
    logic          w_eq;
    logic [CW-1:0] w_pos_end;
    logic          w_full;
    logic          w_sh_more;
    logic          w_out_free;
    logic          w_take;
    logic          w_load;

    assign w_uw       = ucode_rom(r_step);
    assign w_mid_sum  = (CW + 1)'(r_lo) + (CW + 1)'(r_hx) - (CW + 1)'(1);
    assign w_mid      = AW'(w_mid_sum >> 1);
    assign w_gt       = r_key > r_rdata;
    assign w_eq       = r_key == r_rdata;
    assign w_pos_end  = CW'(r_mid) + CW'(r_cmp_gt);
    assign w_full     = r_count == CW'(DEPTH);
    assign w_sh_more  = CW'(r_sp) != r_pos;
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_take     = (w_uw.op == OP_TAKE) && i_in_valid;
    assign w_load     = (w_uw.op == OP_OUT_LOAD) && w_out_free;

    assign o_in_stall  = r_step != STEP_IDLE;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Jump condition select.
    always_comb begin
        unique case (w_uw.cond)
            C_NEVER:       w_jump = 1'b0;
            C_ALWAYS:      w_jump = 1'b1;
            C_NO_INPUT:    w_jump = !i_in_valid;
            C_FULL_ADD:    w_jump = (r_kind == KIND_ADD) && w_full;
            C_NO_SEARCH:   w_jump = !r_sorted || (r_count == '0);
            C_SEARCH_DONE: w_jump = r_lo >= r_hx;
            C_NE:          w_jump = !w_eq;
            C_IS_ADD:      w_jump = r_kind == KIND_ADD;
            C_SH_MORE:     w_jump = w_sh_more;
            C_OUT_FREE:    w_jump = w_out_free;
            default:       w_jump = 1'b1;
        endcase
        n_step = w_jump ? w_uw.target : r_step + t_step'(1);
    end

    // Datapath operation decode.
    always_comb begin
        n_lo      = r_lo;
        n_hx      = r_hx;
        n_mid     = r_mid;
        n_cmp_gt  = r_cmp_gt;
        n_pos     = r_pos;
        n_sp      = r_sp;
        n_res     = r_res;
        n_count   = r_count;
        w_rd_addr = r_mid;
        w_wr_addr = r_sp;
        w_wr_data = r_rdata;
        w_we      = 1'b0;
        unique case (w_uw.op) inside
            OP_NOP, OP_TAKE, OP_OUT_LOAD: begin
            end
            OP_INIT: begin
                n_lo     = '0;
                n_hx     = r_count;
                n_mid    = '0;
                n_cmp_gt = 1'b0;
            end
            OP_PROBE: begin
                // Once the range is empty the last probed slot is kept.
                if (r_lo < r_hx) begin
                    n_mid = w_mid;
                end
                w_rd_addr = w_mid;
            end
            OP_COMPARE: begin
                if (!w_eq) begin
                    n_cmp_gt = w_gt;
                    if (w_gt) begin
                        n_lo = CW'(r_mid) + CW'(1);
                    end else begin
                        n_hx = CW'(r_mid);
                    end
                end
            end
            OP_POS_MID: begin
                n_pos = CW'(r_mid);
            end
            OP_POS_END: begin
                n_pos = (w_pos_end > r_count) ? r_count : w_pos_end;
            end
            OP_POS_COUNT: begin
                n_pos = r_count;
            end
            OP_SH_INIT: begin
                n_sp      = AW'(r_count);
                w_rd_addr = AW'(r_count - CW'(1));
            end
            OP_SH_MOVE: begin
                // Move one key up a slot while fetching the one below it.
                w_rd_addr = r_sp - AW'(2);
                if (w_sh_more) begin
                    w_we      = 1'b1;
                    w_wr_addr = r_sp;
                    w_wr_data = r_rdata;
                    n_sp      = r_sp - AW'(1);
                end
            end
            OP_STORE: begin
                w_we             = 1'b1;
                w_wr_addr        = AW'(r_pos);
                w_wr_data        = r_key;
                n_count          = r_count + CW'(1);
                n_res.found      = 1'b0;
                n_res.index      = INDEX_W'(r_pos);
                n_res.full_error = 1'b0;
            end
            OP_RES_FOUND: begin
                n_res.found      = 1'b1;
                n_res.index      = INDEX_W'(r_pos);
                n_res.full_error = 1'b0;
            end
            OP_RES_MISS: begin
                n_res.found      = 1'b0;
                n_res.index      = '0;
                n_res.full_error = 1'b0;
            end
            OP_RES_ERR: begin
                n_res.found      = 1'b0;
                n_res.index      = '0;
                n_res.full_error = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= STEP_IDLE;
            r_sorted    <= 1'b1;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_step  <= n_step;
            r_count <= n_count;
            if (i_cfg_we) begin
                r_sorted <= i_cfg_wdata;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_kind <= i_in.kind;
            r_key  <= KEY_WIDTH'(i_in.key);
        end
        r_lo     <= n_lo;
        r_hx     <= n_hx;
        r_mid    <= n_mid;
        r_cmp_gt <= n_cmp_gt;
        r_pos    <= n_pos;
        r_sp     <= n_sp;
        r_res    <= n_res;
        if (w_load) begin
            r_out <= r_res;
        end
    end

    // Key memory: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_wr_addr] <= w_wr_data;
        end
        r_rdata <= mem[w_rd_addr];
    end

    // The table never holds more than DEPTH keys.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count above table depth");

    // Every store adds exactly one key.
    a_store_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step == STEP_STORE) |=> (r_count == $past(r_count) + CW'(1)))
        else $error("store did not advance the entry count");

    // An accepted word starts the dispatch steps.
    a_take_dispatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_step == STEP_DISP))
        else $error("accepted word did not reach dispatch");

    // A new answer only comes from the output step.
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_step) == STEP_OUT))
        else $error("answer loaded outside the output step");

    // The shift pointer never passes the insertion slot.
    a_shift_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step == STEP_SH_LOOP) |-> (CW'(r_sp) >= r_pos))
        else $error("shift pointer below insertion slot");

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps

module testbench;

    import stsi_pkg::*;

    localparam int DEPTH       = 256;
    localparam int KEY_WIDTH   = 32;
    localparam int HOLD_CYCLES = 600;
    localparam int QUIET_LIMIT = 5000;
    localparam int IDLE_GAP    = 20;
    localparam int TAIL_CYCLES = 300;

    // Clock, reset and the signals toward the block.
    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      cfg_we    = 1'b0;
    logic      cfg_wdata = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_stall;
    t_in_word  in_word   = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_word out_word;

    // Mirror of the block's key table and mode.
    logic [KEY_WIDTH-1:0] mirror_keys [DEPTH];
    int                   mirror_count  = 0;
    bit                   mirror_sorted = 1'b1;

    // Words waiting to be offered and answers waiting to come back.
    t_in_word  request_q [$];
    t_out_word answer_q [$];

    // Idling profile, receiver hold requests and bookkeeping.
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int holds_wanted   = 0;
    int holds_started  = 0;
    int hold_left      = 0;
    int quiet_cycles   = 0;
    int fail_count     = 0;
    int n_finds        = 0;
    int n_hits         = 0;
    int n_adds         = 0;
    int n_full         = 0;
    int n_append_mode  = 0;

    sorted_table_search_insert_unit #(
        .DEPTH     (DEPTH),
        .KEY_WIDTH (KEY_WIDTH)
    ) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_word)
    );

    always #2 clk = ~clk;

    // Binary search over the held keys. On a miss, pos is the last probe, or the
    // slot after it when the key is larger than that probe.
    function automatic bit search_keys(input logic [KEY_WIDTH-1:0] key, output int pos);
        int lo;
        int hi;
        int mid;
        int dir;
        lo  = 0;
        hi  = mirror_count - 1;
        mid = 0;
        dir = 0;
        while (lo <= hi) begin
            mid = (lo + hi) / 2;
            if (key > mirror_keys[mid]) begin
                dir = 1;
                lo  = mid + 1;
            end else if (key < mirror_keys[mid]) begin
                dir = -1;
                hi  = mid - 1;
            end else begin
                pos = mid;
                return 1'b1;
            end
        end
        pos = mid + ((dir > 0) ? 1 : 0);
        return 1'b0;
    endfunction

    // Applies one request word to the mirror table and returns the answer it must give.
    function automatic t_out_word apply_request(input t_in_word w);
        t_out_word ans;
        int        slot;
        bit        hit;
        ans  = '0;
        slot = 0;
        hit  = 1'b0;
        if (!mirror_sorted) begin
            n_append_mode++;
        end
        if (w.kind == KIND_FIND) begin
            n_finds++;
            if (mirror_sorted && mirror_count > 0) begin
                hit = search_keys(w.key, slot);
            end
            if (hit) begin
                ans.found = 1'b1;
                ans.index = slot[INDEX_W-1:0];
                n_hits++;
            end
        end else if (mirror_count >= DEPTH) begin
            // A full table refuses the add and stays as it is.
            ans.full_error = 1'b1;
            n_full++;
        end else begin
            n_adds++;
            if (mirror_sorted && mirror_count > 0) begin
                void'(search_keys(w.key, slot));
                if (slot > mirror_count) begin
                    slot = mirror_count;
                end
                for (int i = mirror_count; i > slot; i--) begin
                    mirror_keys[i] = mirror_keys[i-1];
                end
            end else begin
                slot = mirror_count;
            end
            mirror_keys[slot] = w.key;
            mirror_count++;
            ans.index = slot[INDEX_W-1:0];
        end
        return ans;
    endfunction

    // Key choice: held keys and their neighbors for hits and duplicates, a narrow
    // range for collisions, the extremes, and full-width random values.
    function automatic logic [KEY_WIDTH-1:0] pick_key();
        logic [KEY_WIDTH-1:0] held;
        int                   r;
        r    = $urandom_range(99);
        held = (mirror_count > 0) ? mirror_keys[$urandom_range(mirror_count - 1)] : '0;
        if (r < 30 && mirror_count > 0) begin
            return held;
        end else if (r < 38 && mirror_count > 0) begin
            return $urandom_range(1) ? held + 1'b1 : held - 1'b1;
        end else if (r < 50) begin
            return KEY_WIDTH'($urandom_range(15));
        end else if (r < 56) begin
            case ($urandom_range(3))
                0:       return '0;
                1:       return '1;
                2:       return {1'b1, {(KEY_WIDTH-1){1'b0}}};
                default: return {1'b0, {(KEY_WIDTH-1){1'b1}}};
            endcase
        end
        return $urandom;
    endfunction

    // Driver: offers queued request words and predicts each one as it is taken.
    always @(posedge clk) begin : driver
        bit taken;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            taken = in_valid && !in_stall;
            if (taken) begin
                answer_q.push_back(apply_request(in_word));
            end
            if (!in_valid || taken) begin
                if (request_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    in_word  <= request_q.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each answer word against the oldest expectation and drives stall.
    always @(posedge clk) begin : monitor
        t_out_word want;
        if (!rst_n) begin
            out_stall <= 1'b0;
            hold_left <= 0;
        end else begin
            if (out_valid && !out_stall) begin
                if (answer_q.size() == 0) begin
                    $error("answer word with no request pending: %h", out_word);
                    fail_count++;
                end else begin
                    want = answer_q.pop_front();
                    if (out_word.found !== want.found) begin
                        $error("found: expected %0d, got %0d", want.found, out_word.found);
                        fail_count++;
                    end
                    if (out_word.index !== want.index) begin
                        $error("index: expected %0d, got %0d", want.index, out_word.index);
                        fail_count++;
                    end
                    if (out_word.full_error !== want.full_error) begin
                        $error("full_error: expected %0d, got %0d",
                               want.full_error, out_word.full_error);
                        fail_count++;
                    end
                end
            end
            // A long hold lets the block fill its output register and stall its input.
            if (hold_left > 0) begin
                out_stall <= 1'b1;
                hold_left <= hold_left - 1;
            end else if (holds_started != holds_wanted) begin
                out_stall     <= 1'b1;
                hold_left     <= HOLD_CYCLES - 1;
                holds_started <= holds_started + 1;
            end else begin
                out_stall <= ($urandom_range(99) < recv_stall_pct);
            end
        end
    end

    // Watchdog on cycles in which no word moves on either side.
    always @(posedge clk) begin : watchdog
        if (!rst_n) begin
            quiet_cycles <= 0;
        end else if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic queue_request(input logic kind, input logic [KEY_WIDTH-1:0] key);
        t_in_word w;
        w.kind = kind;
        w.key  = key;
        while (request_q.size() >= 2) @(negedge clk);
        request_q.push_back(w);
    endtask

    // Waits until every word has been taken and answered, then lets the block settle.
    task automatic wait_idle();
        while (request_q.size() != 0 || in_valid || answer_q.size() != 0) @(negedge clk);
        repeat (IDLE_GAP) @(negedge clk);
    endtask

    task automatic set_sorted_mode(input bit mode);
        @(posedge clk);
        cfg_wdata <= mode;
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we        <= 1'b0;
        mirror_sorted  = mode;
    endtask

    task automatic run_random(input int count, input int send_pct, input int recv_pct,
                              input int add_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        repeat (count) begin
            queue_request(($urandom_range(99) < add_pct) ? KIND_ADD : KIND_FIND, pick_key());
        end
    endtask

    initial begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        set_sorted_mode(1'b1);

        // Empty table, then inserts at the front, the back and ahead of an equal key.
        queue_request(KIND_FIND, '0);
        queue_request(KIND_FIND, '1);
        queue_request(KIND_ADD, 32'd1000);
        queue_request(KIND_ADD, '0);
        queue_request(KIND_ADD, '1);
        queue_request(KIND_ADD, 32'd1000);
        queue_request(KIND_FIND, 32'd1000);
        queue_request(KIND_FIND, '0);
        queue_request(KIND_FIND, '1);
        queue_request(KIND_FIND, 32'd500);
        queue_request(KIND_FIND, 32'hFFFF_FFFE);
        queue_request(KIND_ADD, 32'd500);
        queue_request(KIND_ADD, 32'h8000_0000);
        wait_idle();

        // Append mode: finds miss and adds go to the end, leaving the table out of order.
        set_sorted_mode(1'b0);
        queue_request(KIND_FIND, 32'd1000);
        queue_request(KIND_ADD, 32'd7);
        queue_request(KIND_ADD, '0);
        wait_idle();

        // Search back over the table as it now stands.
        set_sorted_mode(1'b1);
        queue_request(KIND_FIND, 32'd7);
        queue_request(KIND_FIND, '0);
        queue_request(KIND_ADD, 32'd6);
        queue_request(KIND_FIND, 32'h7FFF_FFFF);
        wait_idle();

        // Random part over the idling profiles; the table fills and later adds are refused.
        run_random(300, 0, 0, 25);
        run_random(250, 63, 0, 25);
        wait_idle();
        set_sorted_mode(1'b0);
        run_random(60, 0, 0, 50);
        wait_idle();
        set_sorted_mode(1'b1);
        holds_wanted = holds_wanted + 1;
        run_random(300, 0, 63, 25);
        run_random(300, 30, 30, 25);
        run_random(290, 0, 0, 25);
        wait_idle();
        repeat (TAIL_CYCLES) @(negedge clk);

        $display("Ran %0d finds (%0d hits) and %0d adds, %0d more refused on a full table.",
                 n_finds, n_hits, n_adds, n_full);
        $display("Table ended with %0d keys; %0d words were worked in append mode.",
                 mirror_count, n_append_mode);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
